[sv/pdd_pkg.sv]
package pdd_pkg;

  localparam int unsigned NumDigits = 3;
  localparam int unsigned LevelW    = 7;
  localparam int unsigned PeriodW   = 10;
  localparam int unsigned IntervalW = 8;
  localparam int unsigned HighW     = 9;
  localparam int unsigned SegW      = 8;
  localparam int unsigned CfgDataW  = 10;

  // Top of the power range in percent.
  localparam logic [LevelW-1:0] MaxLevel = 7'd100;

  localparam logic [PeriodW-1:0]   PeriodReset   = 10'd257;
  localparam logic [IntervalW-1:0] IntervalReset = 8'd255;

  // Active-low digit enables: bit0 hundreds, bit1 tens, bit2 units.
  localparam logic [NumDigits-1:0] SelOff      = 3'b111;
  localparam logic [NumDigits-1:0] SelHundreds = 3'b110;
  localparam logic [NumDigits-1:0] SelTens     = 3'b101;
  localparam logic [NumDigits-1:0] SelUnits    = 3'b011;

  typedef enum logic {
    ActScan = 1'b0,
    ActTick = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KeyNone = 2'd0,
    KeyUp   = 2'd1,
    KeyDown = 2'd2
  } key_e;

  typedef enum logic {
    CfgPwmPeriod      = 1'b0,
    CfgRepeatInterval = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    action_e action;
    logic    up;
    logic    down;
  } item_t;

  function automatic logic [SegW-1:0] seg_code(input logic [3:0] digit);
    logic [SegW-1:0] code;
    unique case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h6f;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

[sv/pdd_keys.sv]
module pdd_keys (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  pdd_pkg::item_t                  item_i,
  input  logic [pdd_pkg::IntervalW-1:0]   repeat_interval_i,
  output logic [pdd_pkg::LevelW-1:0]      level_o,
  output logic [pdd_pkg::LevelW-1:0]      level_next_o
);

  pdd_pkg::key_e                   active_q, want;
  logic [pdd_pkg::IntervalW-1:0]   count_q, count_d, base, limit, count_inc;
  logic [pdd_pkg::LevelW-1:0]      level_q, level_d;
  logic                            scan;

  assign scan = step_i && (item_i.action == pdd_pkg::ActScan);

  always_comb begin
    // A key that is already active keeps priority while it stays held.
    priority if (active_q == pdd_pkg::KeyUp && item_i.up) begin
      want = pdd_pkg::KeyUp;
    end else if (active_q == pdd_pkg::KeyDown && item_i.down) begin
      want = pdd_pkg::KeyDown;
    end else if (item_i.up) begin
      want = pdd_pkg::KeyUp;
    end else if (item_i.down) begin
      want = pdd_pkg::KeyDown;
    end else begin
      want = pdd_pkg::KeyNone;
    end

    base      = (want != active_q) ? '0 : count_q;
    limit     = (repeat_interval_i == '0) ? 8'd1 : repeat_interval_i;
    count_inc = base + 8'd1;
    count_d   = base;
    level_d   = level_q;

    if (want != pdd_pkg::KeyNone) begin
      if (count_inc >= limit) begin
        count_d = '0;
        if (want == pdd_pkg::KeyUp) begin
          if (level_q < pdd_pkg::MaxLevel) level_d = level_q + 7'd1;
        end else begin
          if (level_q != '0) level_d = level_q - 7'd1;
        end
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= pdd_pkg::KeyNone;
      count_q  <= '0;
      level_q  <= '0;
    end else if (scan) begin
      active_q <= want;
      count_q  <= count_d;
      level_q  <= level_d;
    end
  end

  assign level_o      = level_q;
  assign level_next_o = scan ? level_d : level_q;

endmodule

[sv/pdd_display.sv]
module pdd_display (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  pdd_pkg::item_t                   item_i,
  input  logic [pdd_pkg::LevelW-1:0]       level_i,
  output logic [pdd_pkg::SegW-1:0]         segments_o,
  output logic [pdd_pkg::NumDigits-1:0]    digit_select_o
);

  typedef enum logic [1:0] {
    PhaseUnits    = 2'd0,
    PhaseTens     = 2'd1,
    PhaseHundreds = 2'd2
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [pdd_pkg::SegW-1:0]        seg_q, seg_d;
  logic [pdd_pkg::NumDigits-1:0]   sel_q, sel_d;
  logic [14:0]                     tens_prod;
  logic [3:0]                      tens_all, tens_digit, units_digit;
  logic [pdd_pkg::LevelW-1:0]      tens_times10;
  logic                            scan;

  assign scan = step_i && (item_i.action == pdd_pkg::ActScan);

  always_comb begin
    // level / 10 by reciprocal; exact for every level below 128.
    tens_prod    = 15'(level_i) * 15'd205;
    tens_all     = tens_prod[14:11];
    tens_digit   = (tens_all >= 4'd10) ? tens_all - 4'd10 : tens_all;
    tens_times10 = 7'({3'b000, tens_all} * 7'd10);
    units_digit  = 4'(level_i - tens_times10);

    phase_d = (phase_q == PhaseHundreds) ? PhaseUnits : phase_e'(phase_q + 2'd1);

    // Leading digits stay dark; the units digit is always shown.
    priority if (phase_d == PhaseHundreds && level_i >= 7'd100) begin
      seg_d = pdd_pkg::seg_code(4'd1);
      sel_d = pdd_pkg::SelHundreds;
    end else if (phase_d == PhaseTens && level_i >= 7'd10) begin
      seg_d = pdd_pkg::seg_code(tens_digit);
      sel_d = pdd_pkg::SelTens;
    end else if (phase_d == PhaseUnits) begin
      seg_d = pdd_pkg::seg_code(units_digit);
      sel_d = pdd_pkg::SelUnits;
    end else begin
      seg_d = '0;
      sel_d = pdd_pkg::SelOff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseUnits;
      seg_q   <= '0;
      sel_q   <= pdd_pkg::SelOff;
    end else if (scan) begin
      phase_q <= phase_d;
      seg_q   <= seg_d;
      sel_q   <= sel_d;
    end
  end

  assign segments_o     = seg_q;
  assign digit_select_o = sel_q;

endmodule

[sv/pdd_pwm.sv]
module pdd_pwm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  pdd_pkg::item_t                item_i,
  input  logic [pdd_pkg::PeriodW-1:0]   pwm_period_i,
  input  logic [pdd_pkg::LevelW-1:0]    level_i,
  output logic                          pwm_o
);

  logic [pdd_pkg::PeriodW-1:0]   pc_q, pc_d, per;
  logic [pdd_pkg::PeriodW:0]     pc_inc;
  logic [pdd_pkg::HighW-1:0]     hr_q, hr_d, hr_cur, duty;
  logic [14:0]                   scaled;
  logic [27:0]                   quot_prod;
  logic                          pwm_q, pwm_d;
  logic                          tick;

  assign tick = step_i && (item_i.action == pdd_pkg::ActTick);

  always_comb begin
    // level * 255 / 100 + 1; the divide is a multiply by 2^19/100.
    scaled    = {level_i, 8'h00} - 15'(level_i);
    quot_prod = 28'(scaled) * 28'd5243;
    duty      = quot_prod[27:19] + 9'd1;

    per    = (pwm_period_i == '0) ? 10'd1 : pwm_period_i;
    hr_cur = (pc_q == '0) ? duty : hr_q;

    if (hr_cur != '0) begin
      pwm_d = 1'b1;
      hr_d  = hr_cur - 9'd1;
    end else begin
      pwm_d = 1'b0;
      hr_d  = hr_cur;
    end

    pc_inc = {1'b0, pc_q} + 11'd1;
    pc_d   = (pc_inc >= {1'b0, per}) ? '0 : pc_inc[pdd_pkg::PeriodW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      hr_q  <= '0;
      pwm_q <= 1'b0;
    end else if (tick) begin
      pc_q  <= pc_d;
      hr_q  <= hr_d;
      pwm_q <= pwm_d;
    end
  end

  assign pwm_o = pwm_q;

endmodule

[sv/pwm_dimmer_with_digit_display.sv]
// PWM dimmer with a three-digit multiplexed 7-segment readout.
// Input stream: each transfer is one item. tuser carries the action (0 = display
// scan that also samples the keys, 1 = PWM timer tick); tdata carries the up key
// in bit 0 and the down key in bit 1. Output stream: one transfer per input item
// with the latched segments, digit enables, PWM level and current power level.
// Configuration: cfg_we_i writes cfg_data_i into the register chosen by
// cfg_index_i (0 = PWM period, 1 = repeat interval) at the clock edge; write
// only while no item is in flight.
// An item sits in the input register while its state update is computed, and
// lands in the state/result registers when it advances, which sets result valid.
// Throughput is one item per cycle while the receiver does not stall; all state
// updates of an item are computed between the input and state/result registers.
// Reset clears the level, key repeat, scan phase and PWM counters, blanks the
// display (all digits off) and drives the PWM output low.
// When the receiver stalls, the result holds and the input register still takes
// one more item; after that tready drops until the result is taken.
module pwm_dimmer_with_digit_display (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // key_up_held, key_down_held
  input  logic                           s_axis_tuser,  // action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // segments[7:0], digit_select[10:8], pwm_out[11], power_level[18:12]
  output logic [23:0]                    m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [pdd_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic                            in_valid_q, out_valid_q, advance;
  pdd_pkg::item_t                  in_item_q;
  logic [pdd_pkg::PeriodW-1:0]     period_q;
  logic [pdd_pkg::IntervalW-1:0]   interval_q;
  logic [pdd_pkg::LevelW-1:0]      level, level_next;
  logic [pdd_pkg::SegW-1:0]        segments;
  logic [pdd_pkg::NumDigits-1:0]   digit_select;
  logic                            pwm;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      in_item_q <= '{action: pdd_pkg::action_e'(s_axis_tuser),
                     up:     s_axis_tdata[0],
                     down:   s_axis_tdata[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= pdd_pkg::PeriodReset;
      interval_q <= pdd_pkg::IntervalReset;
    end else if (cfg_we_i) begin
      unique case (pdd_pkg::cfg_idx_e'(cfg_index_i))
        pdd_pkg::CfgPwmPeriod:      period_q   <= cfg_data_i;
        pdd_pkg::CfgRepeatInterval: interval_q <= cfg_data_i[pdd_pkg::IntervalW-1:0];
      endcase
    end
  end

  pdd_keys u_keys (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (advance),
    .item_i            (in_item_q),
    .repeat_interval_i (interval_q),
    .level_o           (level),
    .level_next_o      (level_next)
  );

  // The display shows the level from before this item's key update.
  pdd_display u_display (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .item_i         (in_item_q),
    .level_i        (level),
    .segments_o     (segments),
    .digit_select_o (digit_select)
  );

  pdd_pwm u_pwm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_item_q),
    .pwm_period_i (period_q),
    .level_i      (level),
    .pwm_o        (pwm)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, level, pwm, digit_select, segments};

  a_one_digit_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(~digit_select))
    else $error("more than one digit enabled");

  a_blank_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_select == pdd_pkg::SelOff) |-> (segments == '0))
    else $error("segments lit while all digits are off");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level <= pdd_pkg::MaxLevel) && (level_next <= pdd_pkg::MaxLevel))
    else $error("power level above maximum");

  a_scan_keeps_pwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_item_q.action == pdd_pkg::ActScan) |=> $stable(pwm))
    else $error("scan item changed the PWM output");

  a_tick_keeps_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_item_q.action == pdd_pkg::ActTick) |=> $stable(level))
    else $error("tick item changed the power level");

endmodule
